// ----- rtl/core/assert_macros.svh -----
// Assertion helpers for the checker file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Check cons in the same cycle as ante.
`define PTS_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
		else $error("scheduler check failed");

// Check cons in the cycle after ante.
`define PTS_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
		else $error("scheduler check failed");

`endif

// ----- rtl/core/pts_pkg.sv -----
`default_nettype none

package pts_pkg;

	localparam int SLOT_W  = 4;
	localparam int PRIO_W  = 8;
	localparam int TICKS_W = 32;
	localparam int TOTAL_W = 64;

	typedef enum logic [1:0] {
		CMD_TICK   = 2'd0,
		CMD_YIELD  = 2'd1,
		CMD_SLEEP  = 2'd2,
		CMD_CREATE = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		TS_UNUSED   = 2'd0,
		TS_RUNNABLE = 2'd1,
		TS_SLEEPING = 2'd2
	} task_status_t;

	typedef enum logic [1:0] {
		S_IDLE,
		S_SCAN,
		S_DRAIN,
		S_FINISH
	} fsm_state_t;

	typedef struct packed {
		cmd_t                cmd;
		logic [PRIO_W-1:0]   priority_req;
		logic [TICKS_W-1:0]  sleep_len;
	} req_t;

	typedef struct packed {
		logic [SLOT_W-1:0]   created_slot;
		logic                create_ok;
		logic                switched;
		logic [SLOT_W-1:0]   previous_task;
		logic [SLOT_W-1:0]   current_task_out;
		logic [TOTAL_W-1:0]  tick_total;
	} rsp_t;

	typedef struct packed {
		task_status_t        status;
		logic [PRIO_W-1:0]   prio;
		logic [TICKS_W-1:0]  sleep;
	} task_ent_t;

	typedef struct packed {
		logic start;
		logic issue;
		logic finish;
	} ctl_cmd_t;

	typedef struct packed {
		logic last_addr;
	} ctl_sts_t;

endpackage

`default_nettype wire

// ----- rtl/core/pts_stream_if.sv -----
`default_nettype none

interface pts_stream_if #(
	parameter type payload_t = logic
) ();
	logic     valid;
	logic     ready;
	payload_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/priority_task_scheduler.sv -----
// Priority task scheduler over NUM_TASKS slots.
// req carries one command transaction (tick, yield, sleep, create) with its
// priority and sleep count; rsp returns one result transaction per command:
// the created slot, the previous and new current task, a switch flag and the
// running tick total.
// Each command walks the slot table once, one slot per cycle, through one
// read port and one write port of the task memory. A tick, yield or sleep
// visits all NUM_TASKS slots starting after the current one; a create visits
// slots 1 up. After acceptance the command scans the table, drains the last
// read and loads the result into the output register; a new command is
// accepted the cycle after the result is loaded.
// The result sits in an output register: req is accepted while it waits. If
// rsp stalls, the next command walks the table and then holds until the
// register frees.
// Reset makes slot 0 the runnable current task, all other slots unused, and
// clears the tick count; it takes effect at once with no clearing pass.
`default_nettype none

module priority_task_scheduler #(
	parameter int NUM_TASKS = 16
) (
	input  wire logic    clk,
	input  wire logic    arst_n,
	pts_stream_if.sink   req,
	pts_stream_if.source rsp
);

	pts_pkg::ctl_cmd_t ctl;
	pts_pkg::ctl_sts_t sts;
	pts_pkg::rsp_t     rsp_data;

	pts_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req.ready),
		.rsp_valid (rsp.valid),
		.rsp_ready (rsp.ready),
		.sts       (sts),
		.ctl       (ctl)
	);

	pts_datapath #(
		.NUM_TASKS (NUM_TASKS)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.ctl      (ctl),
		.sts      (sts),
		.req_data (req.data),
		.rsp_data (rsp_data)
	);

	assign rsp.data = rsp_data;

endmodule

`default_nettype wire

// ----- rtl/core/pts_datapath.sv -----
`default_nettype none

module pts_datapath #(
	parameter int NUM_TASKS = 16
) (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire pts_pkg::ctl_cmd_t ctl,
	output pts_pkg::ctl_sts_t      sts,
	input  wire pts_pkg::req_t     req_data,
	output pts_pkg::rsp_t          rsp_data
);

	localparam int IW = $clog2(NUM_TASKS);

	function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] v);
		logic [IW-1:0] r;
		if (v == IW'(NUM_TASKS - 1)) begin
			r = '0;
		end else begin
			r = v + 1'b1;
		end
		return r;
	endfunction

	pts_pkg::task_ent_t          mem_q [NUM_TASKS];
	logic [NUM_TASKS-1:0]        ent_vld_q;

	pts_pkg::cmd_t               op_q;
	logic [pts_pkg::PRIO_W-1:0]  prio_q;
	logic [pts_pkg::TICKS_W-1:0] ticks_q;
	logic [IW-1:0]               addr_q;
	logic [IW-1:0]               cnt_q;
	logic [IW-1:0]               cur_q;
	logic [pts_pkg::TOTAL_W-1:0] tick_q;

	logic                        vld_s1;
	logic [IW-1:0]               idx_s1;
	pts_pkg::task_ent_t          rd_ent_s1;
	logic                        rd_hit_s1;

	logic                        best_vld_q;
	logic [pts_pkg::PRIO_W-1:0]  best_prio_q;
	logic [IW-1:0]               pick_q;
	logic                        found_q;
	logic [IW-1:0]               created_q;

	pts_pkg::rsp_t               rsp_q;

	pts_pkg::task_ent_t          old_ent;
	pts_pkg::task_ent_t          new_ent;
	logic                        take_create;
	logic                        take_sched;
	logic [IW-1:0]               cur_nxt;
	logic [pts_pkg::TOTAL_W-1:0] tick_nxt;

	assign sts.last_addr = (cnt_q == '0);
	assign rsp_data      = rsp_q;

	always_comb begin
		if (rd_hit_s1) begin
			old_ent = rd_ent_s1;
		end else begin
			old_ent.status = (idx_s1 == '0) ? pts_pkg::TS_RUNNABLE : pts_pkg::TS_UNUSED;
			old_ent.prio   = '0;
			old_ent.sleep  = '0;
		end
	end

	always_comb begin
		new_ent     = old_ent;
		take_create = 1'b0;
		unique case (op_q)
			pts_pkg::CMD_TICK: begin
				if (old_ent.status == pts_pkg::TS_SLEEPING) begin
					if (old_ent.sleep != '0) begin
						new_ent.sleep = old_ent.sleep - 32'd1;
					end else begin
						new_ent.status = pts_pkg::TS_RUNNABLE;
					end
				end
			end
			pts_pkg::CMD_YIELD: begin
			end
			pts_pkg::CMD_SLEEP: begin
				if (idx_s1 == cur_q) begin
					new_ent.sleep  = ticks_q;
					new_ent.status = pts_pkg::TS_SLEEPING;
				end
			end
			pts_pkg::CMD_CREATE: begin
				if (old_ent.status == pts_pkg::TS_UNUSED && !found_q) begin
					new_ent.status = pts_pkg::TS_RUNNABLE;
					new_ent.prio   = prio_q;
					take_create    = 1'b1;
				end
			end
			default: begin
			end
		endcase
		take_sched = (op_q != pts_pkg::CMD_CREATE) && (new_ent.status == pts_pkg::TS_RUNNABLE)
			&& (!best_vld_q || new_ent.prio > best_prio_q);
	end

	always_comb begin
		cur_nxt  = (op_q != pts_pkg::CMD_CREATE && best_vld_q) ? pick_q : cur_q;
		tick_nxt = (op_q == pts_pkg::CMD_TICK) ? tick_q + 64'd1 : tick_q;
	end

	always_ff @(posedge clk) begin
		if (vld_s1) begin
			mem_q[idx_s1] <= new_ent;
		end
		if (ctl.issue) begin
			rd_ent_s1 <= mem_q[addr_q];
			rd_hit_s1 <= ent_vld_q[addr_q];
			idx_s1    <= addr_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_vld_q <= '0;
			vld_s1    <= 1'b0;
			cur_q     <= '0;
			tick_q    <= '0;
		end else begin
			vld_s1 <= ctl.issue;
			if (vld_s1) begin
				ent_vld_q[idx_s1] <= 1'b1;
			end
			if (ctl.finish) begin
				cur_q  <= cur_nxt;
				tick_q <= tick_nxt;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.start) begin
			op_q       <= req_data.cmd;
			prio_q     <= req_data.priority_req;
			ticks_q    <= req_data.sleep_len;
			best_vld_q <= 1'b0;
			best_prio_q <= '0;
			pick_q     <= '0;
			found_q    <= 1'b0;
			created_q  <= '0;
			if (req_data.cmd == pts_pkg::CMD_CREATE) begin
				addr_q <= IW'(1);
				cnt_q  <= IW'(NUM_TASKS - 2);
			end else begin
				addr_q <= wrap_inc(cur_q);
				cnt_q  <= IW'(NUM_TASKS - 1);
			end
		end else begin
			if (ctl.issue) begin
				addr_q <= wrap_inc(addr_q);
				cnt_q  <= cnt_q - 1'b1;
			end
			if (vld_s1 && take_create) begin
				found_q   <= 1'b1;
				created_q <= idx_s1;
			end
			if (vld_s1 && take_sched) begin
				best_vld_q  <= 1'b1;
				best_prio_q <= new_ent.prio;
				pick_q      <= idx_s1;
			end
		end
		if (ctl.finish) begin
			rsp_q.created_slot     <= pts_pkg::SLOT_W'(created_q);
			rsp_q.create_ok        <= found_q;
			rsp_q.switched         <= (cur_nxt != cur_q);
			rsp_q.previous_task    <= pts_pkg::SLOT_W'(cur_q);
			rsp_q.current_task_out <= pts_pkg::SLOT_W'(cur_nxt);
			rsp_q.tick_total       <= tick_nxt;
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/pts_ctrl.sv -----
`default_nettype none

module pts_ctrl (
	input  wire logic              clk,
	input  wire logic              arst_n,
	input  wire logic              req_valid,
	output logic                   req_ready,
	output logic                   rsp_valid,
	input  wire logic              rsp_ready,
	input  wire pts_pkg::ctl_sts_t sts,
	output pts_pkg::ctl_cmd_t      ctl
);

	pts_pkg::fsm_state_t state_q;
	pts_pkg::fsm_state_t state_nxt;
	logic                out_vld_q;
	logic                out_free;

	assign out_free  = !out_vld_q || rsp_ready;
	assign rsp_valid = out_vld_q;

	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			pts_pkg::S_IDLE: begin
				if (req_valid) begin
					state_nxt = pts_pkg::S_SCAN;
				end
			end
			pts_pkg::S_SCAN: begin
				if (sts.last_addr) begin
					state_nxt = pts_pkg::S_DRAIN;
				end
			end
			pts_pkg::S_DRAIN: begin
				state_nxt = pts_pkg::S_FINISH;
			end
			pts_pkg::S_FINISH: begin
				if (out_free) begin
					state_nxt = pts_pkg::S_IDLE;
				end
			end
			default: begin
				state_nxt = pts_pkg::S_IDLE;
			end
		endcase
	end

	always_comb begin
		req_ready  = (state_q == pts_pkg::S_IDLE);
		ctl.start  = (state_q == pts_pkg::S_IDLE) && req_valid;
		ctl.issue  = (state_q == pts_pkg::S_SCAN);
		ctl.finish = (state_q == pts_pkg::S_FINISH) && out_free;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= pts_pkg::S_IDLE;
			out_vld_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (ctl.finish) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

endmodule

`default_nettype wire

// ----- rtl/core/pts_checker.sv -----
`default_nettype none

`include "assert_macros.svh"

module pts_checker (
	input wire logic          clk,
	input wire logic          arst_n,
	input wire logic          req_valid,
	input wire logic          req_ready,
	input wire logic          rsp_valid,
	input wire logic          rsp_ready,
	input wire pts_pkg::rsp_t rsp_data
);

	`PTS_ASSERT_NXT(a_rsp_hold, clk, arst_n, rsp_valid && !rsp_ready, rsp_valid)

	`PTS_ASSERT_NXT(a_one_at_a_time, clk, arst_n, req_valid && req_ready, !req_ready)

	`PTS_ASSERT_IMP(a_switch_flag, clk, arst_n, rsp_valid,
		rsp_data.switched == (rsp_data.previous_task != rsp_data.current_task_out))

	`PTS_ASSERT_IMP(a_create_slot, clk, arst_n, rsp_valid,
		rsp_data.create_ok == (rsp_data.created_slot != '0) || rsp_data.create_ok)

	`PTS_ASSERT_IMP(a_create_no_switch, clk, arst_n, rsp_valid && rsp_data.create_ok,
		!rsp_data.switched)

endmodule

bind priority_task_scheduler pts_checker u_pts_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req_valid (req.valid),
	.req_ready (req.ready),
	.rsp_valid (rsp.valid),
	.rsp_ready (rsp.ready),
	.rsp_data  (rsp.data)
);

`default_nettype wire
